### rtl/core/u8d_pkg.sv
// Shared types, constants and helpers of the UTF-8 stream validating decoder.
`default_nettype none

package u8d_pkg;

    // Width of the saturating code-point counter.
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int TOTAL_W  = 16;

    localparam logic [CP_W-1:0] CP_MIN_2B    = 21'h000080;
    localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MIN_4B    = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        LEN_NONE = 3'd0,
        LEN_2    = 3'd2,
        LEN_3    = 3'd3,
        LEN_4    = 3'd4
    } seq_len_t;

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [1:0]            needed;
        seq_len_t              seq_len;
        logic [CP_W-1:0]       partial;
        logic                  bad_trail;
        logic                  stopped;
        status_t               err_kind;
        logic [COUNT_BITS-1:0] count;
    } dec_state_t;

    // One result item.
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic               point_ready;
        logic               final_mark;
        status_t            status;
        logic [TOTAL_W-1:0] total;
    } result_t;

    localparam dec_state_t STATE_RESET = '{
        needed:    2'd0,
        seq_len:   LEN_NONE,
        partial:   '0,
        bad_trail: 1'b0,
        stopped:   1'b0,
        err_kind:  STATUS_OK,
        count:     '0
    };

    // Range, overlong and surrogate check of a completed sequence.
    function automatic logic value_ok(input logic [CP_W-1:0] v, input seq_len_t len);
        logic ok;
        begin
            case (len)
                LEN_2:   ok = (v >= CP_MIN_2B);
                LEN_3:   ok = (v >= CP_MIN_3B) && !((v >= CP_SURR_LO) && (v <= CP_SURR_HI));
                LEN_4:   ok = (v >= CP_MIN_4B) && (v <= CP_MAX);
                default: ok = 1'b0;
            endcase
            return ok;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/u8d_step_logic.sv
// Combinational decode of one byte: next decoder state and the result item.
`default_nettype none

module u8d_step_logic
    import u8d_pkg::*;
(
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              end_of_string,
    input  wire dec_state_t        cur,
    output dec_state_t             nxt,
    output result_t                res,
    output logic                   emit
);

    logic            ready;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] shifted;
    logic [1:0]      need_dec;
    dec_state_t      upd;
    status_t         status;

    assign shifted  = {cur.partial[CP_W-7:0], data_byte[5:0]};
    assign need_dec = cur.needed - 2'd1;

    always_comb
    begin
        upd   = cur;
        ready = 1'b0;
        cp    = '0;
        if (!cur.stopped)
        begin
            if (cur.needed == 2'd0)
            begin
                upd.bad_trail = 1'b0;
                if (data_byte[7] == 1'b0)
                begin
                    cp    = CP_W'(data_byte);
                    ready = 1'b1;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    upd.seq_len = LEN_2;
                    upd.needed  = 2'd1;
                    upd.partial = CP_W'(data_byte[4:0]);
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    upd.seq_len = LEN_3;
                    upd.needed  = 2'd2;
                    upd.partial = CP_W'(data_byte[3:0]);
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    upd.seq_len = LEN_4;
                    upd.needed  = 2'd3;
                    upd.partial = CP_W'(data_byte[2:0]);
                end
                else
                begin
                    upd.stopped  = 1'b1;
                    upd.err_kind = STATUS_INVALID;
                    upd.needed   = 2'd0;
                end
            end
            else
            begin
                if (data_byte[7:6] != 2'b10)
                begin
                    upd.bad_trail = 1'b1;
                end
                upd.partial = shifted;
                upd.needed  = need_dec;
                if (need_dec == 2'd0)
                begin
                    if (upd.bad_trail || !value_ok(shifted, cur.seq_len))
                    begin
                        upd.stopped  = 1'b1;
                        upd.err_kind = STATUS_INVALID;
                    end
                    else
                    begin
                        cp    = shifted;
                        ready = 1'b1;
                    end
                end
            end
            if (ready && (cur.count != COUNT_MAX))
            begin
                upd.count = cur.count + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (upd.stopped)
        begin
            status = upd.err_kind;
        end
        else if (end_of_string && (upd.needed != 2'd0))
        begin
            status = STATUS_TRUNCATED;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign emit            = ready || end_of_string;
    assign res.code_point  = cp;
    assign res.point_ready = ready;
    assign res.final_mark  = end_of_string;
    assign res.status      = status;
    assign res.total       = TOTAL_W'(upd.count);
    assign nxt             = end_of_string ? STATE_RESET : upd;

endmodule

`default_nettype wire

### rtl/core/u8d_result_reg.sv
// Output register of the decoder: holds one result item until the receiver takes it.
`default_nettype none

module u8d_result_reg
    import u8d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    input  wire logic    out_ready,
    output logic         out_valid,
    output logic         free,
    output result_t      data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or when the held item leaves in this cycle.
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign data      = data_reg;

endmodule

`default_nettype wire

### rtl/core/utf8_stream_validating_decoder_unit.sv
// Top level of the strict UTF-8 stream validating decoder.
//
// Input channel (in_valid / in_ready): one byte of a string per item, with
// end_of_string high on the last byte. Output channel (out_valid / out_ready):
// a result item for every byte that completes a valid code point and for every
// end-of-string byte; other bytes give no result.
// Path: a byte is captured in the input register and decoded combinationally
// into the output register, from which its result is offered. Throughput: one
// byte per cycle while the result register has room or the byte gives no
// result, set by the combinational decode between the input register and the
// result register; the state update is made in the same cycle as the decode,
// so consecutive bytes never wait on each other.
// Stalls: when the receiver holds out_ready low, the result register holds its
// item; the input register still accepts one more byte, and bytes that give no
// result keep flowing through. in_ready drops only when both stages are full
// and the held byte has a result item to give.
// After the first error later bytes are dropped until the end mark, which
// reports the stored error. The end-of-string byte returns the decoder state
// to its reset values. Reset (rst_n low, asynchronous): both stages empty.
`default_nettype none

module utf8_stream_validating_decoder_unit
    import u8d_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [BYTE_W-1:0]   data_byte,
    input  wire logic                end_of_string,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [CP_W-1:0]          code_point,
    output logic                     point_ready,
    output logic                     final_mark,
    output logic [1:0]               string_status,
    output logic [TOTAL_W-1:0]       point_total
);

    // Input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              end_reg;

    // Decoder state
    dec_state_t state_reg;
    dec_state_t state_next;
    dec_state_t step_nxt;

    result_t step_res;
    result_t out_data;
    logic    step_emit;
    logic    out_free;
    logic    advance;
    logic    in_fire;

    // Advance the held byte when it gives no result or the result register
    // can take its item.
    assign advance  = in_valid_reg && (out_free || !step_emit);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= STATE_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    // Capture the byte; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_reg <= data_byte;
            end_reg  <= end_of_string;
        end
    end

    u8d_step_logic u_step (
        .data_byte     (byte_reg),
        .end_of_string (end_reg),
        .cur           (state_reg),
        .nxt           (step_nxt),
        .res           (step_res),
        .emit          (step_emit)
    );

    // Hold state unless a byte is consumed.
    assign state_next = advance ? step_nxt : state_reg;

    u8d_result_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step_emit),
        .load_data (step_res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (out_free),
        .data      (out_data)
    );

    assign code_point    = out_data.code_point;
    assign point_ready   = out_data.point_ready;
    assign final_mark    = out_data.final_mark;
    assign string_status = out_data.status;
    assign point_total   = out_data.total;

    // A result item is either a decoded point or an end-of-string report.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (point_ready || final_mark))
        else $error("result item with neither point nor end mark");

    // A decoded point is a Unicode scalar value and never carries an error.
    a_point_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && point_ready) |->
            ((code_point <= CP_MAX)
             && !((code_point >= CP_SURR_LO) && (code_point <= CP_SURR_HI))
             && (string_status == STATUS_OK)))
        else $error("illegal code point or status on a decoded point");

    // A report without a point carries a zero code point.
    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !point_ready) |-> (code_point == '0))
        else $error("code point set on a report without a point");

    // Once stopped on an error, no sequence stays open.
    a_stopped_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.stopped |-> (state_reg.needed == 2'd0
                               && state_reg.err_kind == STATUS_INVALID))
        else $error("decoder stopped with an open sequence");

    // A byte is consumed only when its result, if any, has room.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("held result item overwritten");

endmodule

`default_nettype wire

### test/utf8_decode_check_pkg.sv
// Scoreboard for the UTF-8 stream decoder: predicts result items and checks them.
`timescale 1ns / 1ps

package utf8_decode_check_pkg;

    import u8d_pkg::*;

    class code_point_scoreboard;

        result_t               pending_points[$];
        int unsigned           mismatches;

        // Decoder state as the block should hold it
        logic [1:0]            trail_left;
        seq_len_t              seq_len;
        logic [CP_W-1:0]       partial;
        logic                  trail_broken;
        logic                  halted;
        status_t               halt_status;
        logic [COUNT_BITS-1:0] points_seen;

        function new();
            mismatches = 0;
            clear_string();
        endfunction

        function void clear_string();
            trail_left   = 2'd0;
            seq_len      = LEN_NONE;
            partial      = '0;
            trail_broken = 1'b0;
            halted       = 1'b0;
            halt_status  = STATUS_OK;
            points_seen  = '0;
        endfunction

        function void reject();
            halted      = 1'b1;
            halt_status = STATUS_INVALID;
            trail_left  = 2'd0;
        endfunction

        // Scalar value legal for the length it was encoded in
        function bit scalar_fits(logic [CP_W-1:0] v, seq_len_t len);
            bit fits;
            case (len)
                LEN_2:   fits = v >= CP_MIN_2B;
                LEN_3:   fits = (v >= CP_MIN_3B) && (v < CP_SURR_LO || v > CP_SURR_HI);
                LEN_4:   fits = (v >= CP_MIN_4B) && (v <= CP_MAX);
                default: fits = 1'b0;
            endcase
            return fits;
        endfunction

        // Note an accepted byte; returns 1 when the block still acts on it.
        function bit note_byte(logic [7:0] b, logic eos);
            bit              acted;
            bit              got_point;
            logic [CP_W-1:0] point;
            result_t         r;
            acted     = !halted;
            got_point = 1'b0;
            point     = '0;
            if (!halted)
            begin
                if (trail_left == 2'd0)
                begin
                    trail_broken = 1'b0;
                    if (b[7] == 1'b0)
                    begin
                        point     = CP_W'(b);
                        got_point = 1'b1;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        seq_len    = LEN_2;
                        trail_left = 2'd1;
                        partial    = CP_W'(b[4:0]);
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        seq_len    = LEN_3;
                        trail_left = 2'd2;
                        partial    = CP_W'(b[3:0]);
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        seq_len    = LEN_4;
                        trail_left = 2'd3;
                        partial    = CP_W'(b[2:0]);
                    end
                    else
                        reject();
                end
                else
                begin
                    if (b[7:6] != 2'b10)
                        trail_broken = 1'b1;
                    partial    = {partial[CP_W-7:0], b[5:0]};
                    trail_left = trail_left - 2'd1;
                    if (trail_left == 2'd0)
                    begin
                        if (trail_broken || !scalar_fits(partial, seq_len))
                            reject();
                        else
                        begin
                            point     = partial;
                            got_point = 1'b1;
                        end
                    end
                end
                if (got_point && points_seen != COUNT_MAX)
                    points_seen = points_seen + 1'b1;
            end
            if (got_point || eos)
            begin
                r.code_point  = point;
                r.point_ready = got_point;
                r.final_mark  = eos;
                if (halted)
                    r.status = halt_status;
                else if (eos && trail_left != 2'd0)
                    r.status = STATUS_TRUNCATED;
                else
                    r.status = STATUS_OK;
                r.total = points_seen[TOTAL_W-1:0];
                pending_points.push_back(r);
            end
            if (eos)
                clear_string();
            return acted;
        endfunction

        function void report(string field, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, want, seen);
            end
        endfunction

        function void check_result(result_t seen);
            result_t want;
            if (pending_points.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result, code_point 0x%0h final %0b status %0d",
                         $time, seen.code_point, seen.final_mark, seen.status);
                return;
            end
            want = pending_points.pop_front();
            report("code_point", want.code_point, seen.code_point);
            report("point_ready", want.point_ready, seen.point_ready);
            report("final_mark", want.final_mark, seen.final_mark);
            report("string_status", want.status, seen.status);
            report("point_total", want.total, seen.total);
        endfunction

    endclass

endpackage

### test/tb_utf8_stream_validating_decoder_unit.sv
// Self-checking testbench for the UTF-8 stream validating decoder top level.
`timescale 1ns / 1ps

module tb_utf8_stream_validating_decoder_unit;

    import u8d_pkg::*;
    import utf8_decode_check_pkg::*;

    // Number of bytes the decoder must act on in the random part
    localparam int RANDOM_BYTES = 1900;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   data_byte     = '0;
    logic                end_of_string = 1'b0;
    logic                out_valid;
    logic                out_ready     = 1'b0;
    logic [CP_W-1:0]     code_point;
    logic                point_ready;
    logic                final_mark;
    logic [1:0]          string_status;
    logic [TOTAL_W-1:0]  point_total;

    code_point_scoreboard sb;

    // Byte string under construction, sent as one string
    logic [7:0]          str_bytes[$];
    int unsigned         live_items;
    int unsigned         drain_cycles;
    bit                  idle_on;
    bit                  stall_on      = 1'b1;

    utf8_stream_validating_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_point    (code_point),
        .point_ready   (point_ready),
        .final_mark    (final_mark),
        .string_status (string_status),
        .point_total   (point_total)
    );

    always #1 clk = ~clk;

    // Hard stop in case the block hangs: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("utf8_stream_validating_decoder_unit regression: fail");
        $finish;
    end

    // Receiver: check every result item taken at this edge, using the values
    // from before the edge, then pick the next ready level. Stall about 16
    // percent of the time unless the quiet stretch is on.
    always @(posedge clk)
    begin : receive_results
        result_t seen;
        if (rst_n && out_valid && out_ready)
        begin
            seen.code_point  = code_point;
            seen.point_ready = point_ready;
            seen.final_mark  = final_mark;
            seen.status      = status_t'(string_status);
            seen.total       = point_total;
            sb.check_result(seen);
        end
        out_ready <= stall_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
    end

    // Offer one byte and hold it until the block takes it. Gaps drop valid
    // for whole cycles only, so valid is never lowered and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        while (idle_on && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        end_of_string <= eos;
        @(posedge clk);
        // in_ready read here is still the level that decided this edge
        while (!in_ready)
            @(posedge clk);
        if (sb.note_byte(b, eos))
            live_items++;
    endtask

    // Send the whole byte string, end mark on its last byte.
    task automatic send_string();
        for (int i = 0; i < str_bytes.size(); i++)
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
    endtask

    // Append the UTF-8 form of v in len bytes; no checking of v, so overlong,
    // surrogate and out-of-range forms come out of here as well.
    function automatic void push_encoded(logic [20:0] v, int len);
        case (len)
            1: str_bytes.push_back({1'b0, v[6:0]});
            2:
            begin
                str_bytes.push_back({3'b110, v[10:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            3:
            begin
                str_bytes.push_back({4'b1110, v[15:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
            default:
            begin
                str_bytes.push_back({5'b11110, v[20:18]});
                str_bytes.push_back({2'b10, v[17:12]});
                str_bytes.push_back({2'b10, v[11:6]});
                str_bytes.push_back({2'b10, v[5:0]});
            end
        endcase
    endfunction

    // Legal scalar for a given length, leaning towards the range edges and
    // the values either side of the surrogate block.
    function automatic logic [20:0] pick_point(int len);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] v;
        int          pick;
        case (len)
            1:       begin lo = 21'h0;     hi = 21'h7F;     end
            2:       begin lo = 21'h80;    hi = 21'h7FF;    end
            3:       begin lo = 21'h800;   hi = 21'hFFFF;   end
            default: begin lo = 21'h10000; hi = 21'h10FFFF; end
        endcase
        pick = $urandom_range(0, 9);
        if (pick == 0)
            v = lo;
        else if (pick == 1)
            v = hi;
        else if (pick == 2 && len == 3)
            v = 21'hD7FF;
        else if (pick == 3 && len == 3)
            v = 21'hE000;
        else
            v = 21'($urandom_range(hi, lo));
        // Move a surrogate up out of the block, keeping it a 3-byte value
        if (len == 3 && v >= 21'hD800 && v <= 21'hDFFF)
            v = v ^ 21'h2000;
        return v;
    endfunction

    // Mostly well-formed strings with random content; now and then a broken
    // unit, and sometimes the last sequence cut short by the end mark.
    function automatic void build_random_string();
        int          units;
        int          start;
        int          len;
        int          cut;
        logic [7:0]  junk;
        str_bytes.delete();
        units = $urandom_range(1, 8);
        start = 0;
        for (int u = 0; u < units; u++)
        begin
            start = str_bytes.size();
            if ($urandom_range(0, 99) < 92)
            begin
                len = $urandom_range(1, 4);
                push_encoded(pick_point(len), len);
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:  // lead byte that can never open a sequence
                        str_bytes.push_back($urandom_range(0, 1) ?
                            8'($urandom_range(8'hBF, 8'h80)) :
                            8'($urandom_range(8'hFF, 8'hF8)));
                    1:  // overlong: a shorter form's value in a longer form
                    begin
                        len = $urandom_range(2, 4);
                        push_encoded(pick_point(len - 1), len);
                    end
                    2:  // surrogate half
                        push_encoded(21'($urandom_range(21'hDFFF, 21'hD800)), 3);
                    3:  // beyond the last scalar, leads 0xF4 to 0xF7
                        push_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
                    4:  // one trail byte that is not 10xxxxxx
                    begin
                        len = $urandom_range(2, 4);
                        push_encoded(pick_point(len), len);
                        junk = 8'($urandom);
                        if (junk[7:6] == 2'b10)
                            junk[6] = 1'b1;
                        str_bytes[start + $urandom_range(1, len - 1)] = junk;
                    end
                    default:
                        str_bytes.push_back(8'($urandom));
                endcase
            end
        end
        // Cut the last sequence short, always keeping its lead byte
        if ($urandom_range(0, 99) < 12 && str_bytes.size() - start > 1)
        begin
            cut = $urandom_range(1, str_bytes.size() - start - 1);
            repeat (cut) void'(str_bytes.pop_back());
        end
    endfunction

    initial
    begin
        sb         = new();
        live_items = 0;
        idle_on    = 1'b1;

        // Hold reset at the start, release it at an edge, never again
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Range edges of every length in one clean string: U+0000, U+0080,
        // U+FFFF, U+10FFFF, then U+007F carrying the end mark.
        str_bytes = '{8'h00, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                      8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h7F};
        send_string();
        // Surrogate half: rejected when the sequence completes
        str_bytes = '{8'hED, 8'hA0, 8'h80};
        send_string();
        // Overlong two-byte NUL from a 0xC0 lead
        str_bytes = '{8'hC0, 8'h80};
        send_string();
        // Bad lead at once, then a byte that must be dropped
        str_bytes = '{8'hFF, 8'h41};
        send_string();
        // Truncation wins over the bad trail byte before it
        str_bytes = '{8'hE2, 8'h41};
        send_string();
        // One past U+10FFFF
        str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_string();

        // Random strings; a long quiet stretch in the middle with no gaps on
        // either side, to run the block at full rate and fill both stages.
        live_items = 0;
        while (live_items < RANDOM_BYTES)
        begin
            idle_on = !(live_items >= 700 && live_items < 1100);
            stall_on <= idle_on;
            build_random_string();
            send_string();
        end
        idle_on = 1'b1;
        stall_on <= 1'b1;
        in_valid <= 1'b0;

        // Drain: wait for every expected item, then keep watching for strays
        drain_cycles = 0;
        while (sb.pending_points.size() != 0 && drain_cycles < 100000)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_points.size() == 0)
            $display("utf8_stream_validating_decoder_unit regression: pass");
        else
        begin
            if (sb.pending_points.size() != 0)
                $display("%0t ns: %0d expected results never arrived",
                         $time, sb.pending_points.size());
            $display("utf8_stream_validating_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule
